// ===== rtl/tsm_pkg.sv =====
`default_nettype none

package tsm_pkg;

  // Field widths.
  localparam int POS_W   = 20;
  localparam int SLOPE_W = 16;
  localparam int VAR_W   = 32;
  localparam int CHI_W   = 24;

  localparam logic [CHI_W-1:0] CHI_MAX = {CHI_W{1'b1}};

  // Squared tolerance slopes (80 and 300 mm, squared).
  localparam logic [12:0] X_TOL_SLOPE_SQ = 13'd6400;
  localparam logic [16:0] Y_TOL_SLOPE_SQ = 17'd90000;

  // Divider geometry: one quotient bit per stage, plus an entry stage.
  localparam int DIV_NUM_W = 70;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_Q_W   = CHI_W;
  localparam int DIV_REM_W = DIV_DEN_W + DIV_Q_W;
  localparam int DIV_LAT   = DIV_Q_W + 1;

  // Register stages ahead of the dividers.
  localparam int FRONT_DEPTH = 6;
  localparam int CTRL_DEPTH  = FRONT_DEPTH + DIV_LAT;

  // Configuration register map.
  localparam int ADDR_W = 5;
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_Z_MAGNET        = 3'd0;
  localparam reg_idx_t REG_Z_MAGNET_TX_SQ  = 3'd1;
  localparam reg_idx_t REG_Z_MAGNET_DS_SQ  = 3'd2;
  localparam reg_idx_t REG_Z_MATCH_PLANE   = 3'd3;
  localparam reg_idx_t REG_X_TOLERANCE     = 3'd4;
  localparam reg_idx_t REG_Y_TOLERANCE     = 3'd5;
  localparam reg_idx_t REG_BEND_COEFF      = 3'd6;
  localparam reg_idx_t REG_CHI2_CUT        = 3'd7;

  typedef struct packed {
    logic        [17:0] z_magnet;
    logic signed [18:0] z_magnet_tx_sq;
    logic signed [18:0] z_magnet_dslope_sq;
    logic        [17:0] z_match_plane;
    logic        [13:0] x_tolerance;
    logic        [13:0] y_tolerance;
    logic signed [18:0] bend_coefficient;
    logic        [23:0] chi2_cut;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    z_magnet:           18'd83200,
    z_magnet_tx_sq:     -19'sd27200,
    z_magnet_dslope_sq: 19'sd8000,
    z_match_plane:      18'd134720,
    x_tolerance:        14'd128,
    y_tolerance:        14'd96,
    bend_coefficient:   -19'sd16000,
    chi2_cut:           24'd1024
  };

endpackage

`default_nettype wire

// ===== rtl/tsm_if.sv =====
`default_nettype none

// Pair channel: one upstream and one downstream track state per word.
interface tsm_pair_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tsm_pkg::POS_W-1:0]      up_x;
  logic signed [tsm_pkg::POS_W-1:0]      up_y;
  logic signed [tsm_pkg::POS_W-1:0]      up_z;
  logic signed [tsm_pkg::SLOPE_W-1:0]    up_tx;
  logic signed [tsm_pkg::SLOPE_W-1:0]    up_ty;
  logic                                  up_bad;
  logic signed [tsm_pkg::POS_W-1:0]      down_x;
  logic signed [tsm_pkg::POS_W-1:0]      down_y;
  logic signed [tsm_pkg::POS_W-1:0]      down_z;
  logic signed [tsm_pkg::SLOPE_W-1:0]    down_tx;
  logic signed [tsm_pkg::SLOPE_W-1:0]    down_ty;
  logic        [tsm_pkg::VAR_W-1:0]      down_ty_variance;

  modport source (output valid, up_x, up_y, up_z, up_tx, up_ty, up_bad,
                  down_x, down_y, down_z, down_tx, down_ty, down_ty_variance,
                  input ready);
  modport sink (input valid, up_x, up_y, up_z, up_tx, up_ty, up_bad,
                down_x, down_y, down_z, down_tx, down_ty, down_ty_variance,
                output ready);
endinterface

// Result channel: chi-square and the cut decision.
interface tsm_result_if;
  logic                       valid;
  logic                       ready;
  logic [tsm_pkg::CHI_W-1:0]  chi_square;
  logic                       accepted;

  modport source (output valid, chi_square, accepted, input ready);
  modport sink (input valid, chi_square, accepted, output ready);
endinterface

`default_nettype wire

// ===== rtl/track_segment_match_chi2_unit.sv =====
// Throughput: one pair per cycle while the result is not stalled; six arithmetic
// stages feed three 25-stage bit-per-stage dividers that run side by side.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits and loads the register
// defaults; data registers are not reset.
`default_nettype none

module track_segment_match_chi2_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  tsm_pair_if.sink                         pair_in,
  tsm_result_if.source                     result_out,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tsm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  tsm_pkg::cfg_t     cfg;
  tsm_pkg::reg_idx_t reg_idx;
  logic              en;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= tsm_pkg::CFG_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        tsm_pkg::REG_Z_MAGNET:       cfg.z_magnet           <= pwdata[17:0];
        tsm_pkg::REG_Z_MAGNET_TX_SQ: cfg.z_magnet_tx_sq     <= $signed(pwdata[18:0]);
        tsm_pkg::REG_Z_MAGNET_DS_SQ: cfg.z_magnet_dslope_sq <= $signed(pwdata[18:0]);
        tsm_pkg::REG_Z_MATCH_PLANE:  cfg.z_match_plane      <= pwdata[17:0];
        tsm_pkg::REG_X_TOLERANCE:    cfg.x_tolerance        <= pwdata[13:0];
        tsm_pkg::REG_Y_TOLERANCE:    cfg.y_tolerance        <= pwdata[13:0];
        tsm_pkg::REG_BEND_COEFF:     cfg.bend_coefficient   <= $signed(pwdata[18:0]);
        tsm_pkg::REG_CHI2_CUT:       cfg.chi2_cut           <= pwdata[23:0];
      endcase
    end
  end

  // Register read-back, signed registers sign-extended.
  always_comb begin
    unique case (reg_idx)
      tsm_pkg::REG_Z_MAGNET:       prdata = 32'(cfg.z_magnet);
      tsm_pkg::REG_Z_MAGNET_TX_SQ: prdata = 32'(cfg.z_magnet_tx_sq);
      tsm_pkg::REG_Z_MAGNET_DS_SQ: prdata = 32'(cfg.z_magnet_dslope_sq);
      tsm_pkg::REG_Z_MATCH_PLANE:  prdata = 32'(cfg.z_match_plane);
      tsm_pkg::REG_X_TOLERANCE:    prdata = 32'(cfg.x_tolerance);
      tsm_pkg::REG_Y_TOLERANCE:    prdata = 32'(cfg.y_tolerance);
      tsm_pkg::REG_BEND_COEFF:     prdata = 32'(cfg.bend_coefficient);
      tsm_pkg::REG_CHI2_CUT:       prdata = 32'(cfg.chi2_cut);
    endcase
  end

  // The pipeline moves whenever the output register is free or drained.
  assign en            = !result_out.valid || result_out.ready;
  assign pair_in.ready = en;

  // Valid and saturation flags travel alongside the data.
  logic vld_q [0:tsm_pkg::CTRL_DEPTH-1];
  logic sat_q [0:tsm_pkg::CTRL_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tsm_pkg::CTRL_DEPTH; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= pair_in.valid;
      for (int i = 1; i < tsm_pkg::CTRL_DEPTH; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_q[0] <= pair_in.up_bad || (pair_in.down_ty_variance == '0);
      for (int i = 1; i < tsm_pkg::CTRL_DEPTH; i++) sat_q[i] <= sat_q[i-1];
    end
  end

  // Stage 1: differences of positions and slopes, and squares of the slopes.
  logic signed [16:0] ds_c, dty_c;
  logic signed [33:0] ds_sq_c, dty_sq_c;
  logic signed [31:0] utx_sq_c, uty_sq_c;

  assign ds_c     = 17'(pair_in.up_tx) - 17'(pair_in.down_tx);
  assign dty_c    = 17'(pair_in.down_ty) - 17'(pair_in.up_ty);
  assign ds_sq_c  = 34'(ds_c) * 34'(ds_c);
  assign dty_sq_c = 34'(dty_c) * 34'(dty_c);
  assign utx_sq_c = 32'(pair_in.up_tx) * 32'(pair_in.up_tx);
  assign uty_sq_c = 32'(pair_in.up_ty) * 32'(pair_in.up_ty);

  logic        [31:0] s1_ds2, s1_dty2, s1_utx2, s1_uty2;
  logic signed [20:0] s1_dxu, s1_dyu;
  logic signed [19:0] s1_uz, s1_dz;
  logic signed [15:0] s1_utx, s1_uty, s1_dtx, s1_dty;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ds2  <= ds_sq_c[31:0];
      s1_dty2 <= dty_sq_c[31:0];
      s1_utx2 <= utx_sq_c;
      s1_uty2 <= uty_sq_c;
      s1_dxu  <= 21'(pair_in.down_x) - 21'(pair_in.up_x);
      s1_dyu  <= 21'(pair_in.down_y) - 21'(pair_in.up_y);
      s1_uz   <= pair_in.up_z;
      s1_dz   <= pair_in.down_z;
      s1_utx  <= pair_in.up_tx;
      s1_uty  <= pair_in.up_ty;
      s1_dtx  <= pair_in.down_tx;
      s1_dty  <= pair_in.down_ty;
    end
  end

  // Stage 2: coefficient products for kink z, bend and tolerances.
  logic signed [32:0] ds2_s, utx2_s;
  logic signed [20:0] zmp_dz_c;
  logic        [31:0] teta2_c;

  assign ds2_s    = $signed({1'b0, s1_ds2});
  assign utx2_s   = $signed({1'b0, s1_utx2});
  assign zmp_dz_c = $signed({3'b0, cfg.z_match_plane}) - 21'(s1_dz);
  assign teta2_c  = s1_utx2 + s1_uty2;

  logic signed [51:0] s2_t1, s2_t2, s2_bendp;
  logic        [44:0] s2_tolxp;
  logic        [48:0] s2_tolyp;
  logic signed [36:0] s2_ydp;
  logic        [27:0] s2_xt2, s2_yt2;
  logic        [31:0] s2_dty2;
  logic signed [20:0] s2_dxu, s2_dyu;
  logic signed [19:0] s2_uz, s2_dz;
  logic signed [15:0] s2_utx, s2_uty, s2_dtx;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_t1    <= 52'(cfg.z_magnet_tx_sq) * 52'(utx2_s);
      s2_t2    <= 52'(cfg.z_magnet_dslope_sq) * 52'(ds2_s);
      s2_bendp <= 52'(cfg.bend_coefficient) * 52'(ds2_s);
      s2_tolxp <= 45'(s1_ds2) * 45'(tsm_pkg::X_TOL_SLOPE_SQ);
      s2_tolyp <= 49'(teta2_c) * 49'(tsm_pkg::Y_TOL_SLOPE_SQ);
      s2_ydp   <= 37'(zmp_dz_c) * 37'(s1_dty);
      s2_xt2   <= 28'(cfg.x_tolerance) * 28'(cfg.x_tolerance);
      s2_yt2   <= 28'(cfg.y_tolerance) * 28'(cfg.y_tolerance);
      s2_dty2  <= s1_dty2;
      s2_dxu   <= s1_dxu;
      s2_dyu   <= s1_dyu;
      s2_uz    <= s1_uz;
      s2_dz    <= s1_dz;
      s2_utx   <= s1_utx;
      s2_uty   <= s1_uty;
      s2_dtx   <= s1_dtx;
    end
  end

  // Stage 3: round kink z, bend and tolerances.
  logic signed [53:0] zsum_c;
  logic signed [52:0] bsum_c;
  logic        [45:0] tolx_r_c;
  logic        [49:0] toly_r_c;

  assign zsum_c   = $signed({8'b0, cfg.z_magnet, 28'b0}) + 54'(s2_t1) + 54'(s2_t2)
                    + 54'sd134217728;
  assign bsum_c   = 53'(s2_bendp) + 53'sd134217728;
  assign tolx_r_c = 46'(s2_tolxp) + 46'd524288;
  assign toly_r_c = 50'(s2_tolyp) + 50'd524288;

  logic signed [25:0] s3_zf;
  logic signed [24:0] s3_bend;
  logic        [29:0] s3_tolx, s3_toly;
  logic        [31:0] s3_dty2;
  logic signed [36:0] s3_ydp;
  logic signed [20:0] s3_dxu, s3_dyu;
  logic signed [19:0] s3_uz, s3_dz;
  logic signed [15:0] s3_utx, s3_uty, s3_dtx;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_zf   <= zsum_c[53:28];
      s3_bend <= bsum_c[52:28];
      s3_tolx <= 30'(s2_xt2) + 30'(tolx_r_c[45:20]);
      s3_toly <= 30'(s2_yt2) + 30'(toly_r_c[49:20]);
      s3_dty2 <= s2_dty2;
      s3_ydp  <= s2_ydp;
      s3_dxu  <= s2_dxu;
      s3_dyu  <= s2_dyu;
      s3_uz   <= s2_uz;
      s3_dz   <= s2_dz;
      s3_utx  <= s2_utx;
      s3_uty  <= s2_uty;
      s3_dtx  <= s2_dtx;
    end
  end

  // Stage 4: slope products of the extrapolation.
  logic signed [26:0] zf_dz_c, zf_uz_c;
  logic signed [25:0] zmp_uz_c;

  assign zf_dz_c  = 27'(s3_zf) - 27'(s3_dz);
  assign zf_uz_c  = 27'(s3_zf) - 27'(s3_uz);
  assign zmp_uz_c = $signed({8'b0, cfg.z_match_plane}) - 26'(s3_uz) + 26'(s3_bend);

  logic signed [42:0] s4_xa, s4_xb, s4_yb;
  logic signed [36:0] s4_ydp;
  logic signed [20:0] s4_dxu, s4_dyu;
  logic        [29:0] s4_tolx, s4_toly;
  logic        [31:0] s4_dty2;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_xa   <= 43'(zf_dz_c) * 43'(s3_dtx);
      s4_xb   <= 43'(zf_uz_c) * 43'(s3_utx);
      s4_yb   <= 43'(zmp_uz_c) * 43'(s3_uty);
      s4_ydp  <= s3_ydp;
      s4_dxu  <= s3_dxu;
      s4_dyu  <= s3_dyu;
      s4_tolx <= s3_tolx;
      s4_toly <= s3_toly;
      s4_dty2 <= s3_dty2;
    end
  end

  // Stage 5: distances, rounded half up.
  logic signed [45:0] sx_c, sy_c;

  assign sx_c = $signed({s4_dxu[20], s4_dxu, 14'b0}) + 46'(s4_xa) - 46'(s4_xb) + 46'sd8192;
  assign sy_c = $signed({s4_dyu[20], s4_dyu, 14'b0}) + 46'(s4_ydp) - 46'(s4_yb) + 46'sd8192;

  logic signed [31:0] s5_distx, s5_disty;
  logic        [29:0] s5_tolx, s5_toly;
  logic        [31:0] s5_dty2;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_distx <= sx_c[45:14];
      s5_disty <= sy_c[45:14];
      s5_tolx  <= s4_tolx;
      s5_toly  <= s4_toly;
      s5_dty2  <= s4_dty2;
    end
  end

  // Stage 6: squared distances.
  logic [31:0] ax_c, ay_c;

  assign ax_c = s5_distx[31] ? 32'(-s5_distx) : 32'(s5_distx);
  assign ay_c = s5_disty[31] ? 32'(-s5_disty) : 32'(s5_disty);

  logic [61:0] s6_dx2, s6_dy2;
  logic [29:0] s6_tolx, s6_toly;
  logic [31:0] s6_dty2;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_dx2  <= 62'(ax_c) * 62'(ax_c);
      s6_dy2  <= 62'(ay_c) * 62'(ay_c);
      s6_tolx <= s5_tolx;
      s6_toly <= s5_toly;
      s6_dty2 <= s5_dty2;
    end
  end

  // Variance delayed to line up with the divider entry.
  logic [tsm_pkg::VAR_W-1:0] dvar_q [0:tsm_pkg::FRONT_DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dvar_q[0] <= pair_in.down_ty_variance;
      for (int i = 1; i < tsm_pkg::FRONT_DEPTH; i++) dvar_q[i] <= dvar_q[i-1];
    end
  end

  // Three dividers for the x, y and slope terms.
  logic [tsm_pkg::CHI_W-1:0] qx, qy, qt;

  tsm_div u_div_x (
    .clk (clk),
    .en  (en),
    .num ({s6_dx2, 8'b0}),
    .den (tsm_pkg::DIV_DEN_W'(s6_tolx)),
    .quo (qx)
  );

  tsm_div u_div_y (
    .clk (clk),
    .en  (en),
    .num ({s6_dy2, 8'b0}),
    .den (tsm_pkg::DIV_DEN_W'(s6_toly)),
    .quo (qy)
  );

  tsm_div u_div_t (
    .clk (clk),
    .en  (en),
    .num (tsm_pkg::DIV_NUM_W'({s6_dty2, 16'b0})),
    .den (dvar_q[tsm_pkg::FRONT_DEPTH-1]),
    .quo (qt)
  );

  // Sum, saturate and compare with the cut.
  logic [tsm_pkg::CHI_W+1:0] sum_c;
  logic [tsm_pkg::CHI_W-1:0] chi_c;

  assign sum_c = (tsm_pkg::CHI_W+2)'(qx) + (tsm_pkg::CHI_W+2)'(qy)
                 + (tsm_pkg::CHI_W+2)'(qt);
  assign chi_c = (sat_q[tsm_pkg::CTRL_DEPTH-1]
                  || sum_c > (tsm_pkg::CHI_W+2)'(tsm_pkg::CHI_MAX))
                 ? tsm_pkg::CHI_MAX : sum_c[tsm_pkg::CHI_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (en) begin
      result_out.valid <= vld_q[tsm_pkg::CTRL_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_out.chi_square <= chi_c;
      result_out.accepted   <= chi_c < cfg.chi2_cut;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tsm_div.sv =====
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Quotients that do not fit, and a zero divisor, come out saturated.
module tsm_div (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [tsm_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic [tsm_pkg::DIV_DEN_W-1:0]  den,
  output logic      [tsm_pkg::DIV_Q_W-1:0]    quo
);

  localparam int QW = tsm_pkg::DIV_Q_W;
  localparam int RW = tsm_pkg::DIV_REM_W;

  logic [RW-1:0]                    rem_q [0:QW];
  logic [tsm_pkg::DIV_DEN_W-1:0]    den_q [0:QW];
  logic [QW-1:0]                    quo_q [0:QW];
  logic                             ovf_q [0:QW];

  logic [tsm_pkg::DIV_NUM_W-1:0] limit;
  logic                          ovf;

  // The quotient overflows when the dividend reaches the divisor times 2^QW.
  assign limit = tsm_pkg::DIV_NUM_W'({den, {QW{1'b0}}});
  assign ovf   = (den == '0) || (num >= limit);

  // Entry stage: once overflow is excluded the remainder fits in RW bits.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= ovf ? '0 : num[RW-1:0];
      den_q[0] <= den;
      quo_q[0] <= '0;
      ovf_q[0] <= ovf;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic [RW-1:0] sub;

    assign sub = RW'(den_q[k]) << SH;

    // Try the shifted divisor and keep the difference when it fits.
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_q[k] >= sub) begin
          rem_q[k+1] <= rem_q[k] - sub;
          quo_q[k+1] <= quo_q[k] | (QW'(1) << SH);
        end else begin
          rem_q[k+1] <= rem_q[k];
          quo_q[k+1] <= quo_q[k];
        end
        den_q[k+1] <= den_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quo = ovf_q[QW] ? '1 : quo_q[QW];

endmodule

`default_nettype wire

// ===== rtl/tsm_chk.sv =====
`default_nettype none

module tsm_chk (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [tsm_pkg::CHI_W-1:0]  chi_square,
  input wire logic                       accepted
);

  // The input side is held off exactly while a result word waits.
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not match output stall");

  // A saturated chi-square can never pass any cut.
  a_saturated_rejected: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> (chi_square != tsm_pkg::CHI_MAX))
    else $error("saturated chi-square accepted");

  // Reset empties the pipeline.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid right after reset");

  // A stalled result word holds.
  a_output_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(chi_square) && $stable(accepted)))
    else $error("stalled result word changed");

endmodule

bind track_segment_match_chi2_unit tsm_chk u_tsm_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (pair_in.ready),
  .out_valid  (result_out.valid),
  .out_ready  (result_out.ready),
  .chi_square (result_out.chi_square),
  .accepted   (result_out.accepted)
);

`default_nettype wire

// ===== tb/sv/track_segment_match_chi2_unit_tb.sv =====
module track_segment_match_chi2_unit_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tsm_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tsm_pair_if pair_ch ();
  tsm_result_if res_ch ();

  track_segment_match_chi2_unit DUT (
    .clk(clk), .rst(rst), .pair_in(pair_ch.sink), .result_out(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // One pair word as the channel carries it.
  typedef struct packed {
    logic signed [19:0] up_x;
    logic signed [19:0] up_y;
    logic signed [19:0] up_z;
    logic signed [15:0] up_tx;
    logic signed [15:0] up_ty;
    logic up_bad;
    logic signed [19:0] down_x;
    logic signed [19:0] down_y;
    logic signed [19:0] down_z;
    logic signed [15:0] down_tx;
    logic signed [15:0] down_ty;
    logic [31:0] down_ty_variance;
  } pair_t;

  typedef struct packed {
    logic [23:0] chi_square;
    logic accepted;
  } score_t;

  localparam longint MAX_CYCLES = 600000;

  pair_t pending_pairs[$];
  score_t expected_scores[$];
  tsm_pkg::cfg_t cfg_shadow;
  bit failed = 1'b0;
  longint cycle_count = 0;
  int send_gap = 0;
  int take_gap = 0;
  int next_take_gap;

  initial begin
    forever #6 clk = ~clk;
  end

  // Division by 2^s, rounded half up: add half, then floor shift.
  function automatic longint round_shift(longint v, int s);
    longint t;
    t = v + (longint'(1) <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic longint sat_term(longint num, longint den);
    longint q;
    if (den == 0) return longint'(tsm_pkg::CHI_MAX);
    q = num / den;
    return (q > longint'(tsm_pkg::CHI_MAX)) ? longint'(tsm_pkg::CHI_MAX) : q;
  endfunction

  // Chi-square of one pair under the current register settings.
  function automatic score_t score_pair(pair_t p);
    score_t r;
    longint ds, ds2, zf, bend, dx, dy, tolx, toly, tyt, chi, dty;
    longint utx, uty;
    utx = p.up_tx;
    uty = p.up_ty;
    if (p.up_bad || p.down_ty_variance == 0) begin
      chi = longint'(tsm_pkg::CHI_MAX);
    end else begin
      ds = utx - longint'(p.down_tx);
      ds2 = ds * ds;
      zf = round_shift(longint'(cfg_shadow.z_magnet) * (longint'(1) <<< 28)
           + longint'(cfg_shadow.z_magnet_tx_sq) * utx * utx
           + longint'(cfg_shadow.z_magnet_dslope_sq) * ds2, 28);
      bend = round_shift(longint'(cfg_shadow.bend_coefficient) * ds2, 28);
      dx = round_shift((longint'(p.down_x) - longint'(p.up_x)) * 16384
           + (zf - longint'(p.down_z)) * longint'(p.down_tx)
           - (zf - longint'(p.up_z)) * utx, 14);
      dy = round_shift((longint'(p.down_y) - longint'(p.up_y)) * 16384
           + (longint'(cfg_shadow.z_match_plane) - longint'(p.down_z))
             * longint'(p.down_ty)
           - (longint'(cfg_shadow.z_match_plane) - longint'(p.up_z) + bend) * uty,
           14);
      tolx = longint'(cfg_shadow.x_tolerance) * longint'(cfg_shadow.x_tolerance)
             + ((ds2 * 6400 + (1 << 19)) >>> 20);
      toly = longint'(cfg_shadow.y_tolerance) * longint'(cfg_shadow.y_tolerance)
             + (((utx * utx + uty * uty) * 90000 + (1 << 19)) >>> 20);
      dty = longint'(p.down_ty) - uty;
      tyt = sat_term((dty * dty) <<< 16, longint'(p.down_ty_variance));
      chi = sat_term((dx * dx) <<< 8, tolx) + sat_term((dy * dy) <<< 8, toly) + tyt;
      if (chi > longint'(tsm_pkg::CHI_MAX)) chi = longint'(tsm_pkg::CHI_MAX);
    end
    r.chi_square = chi[23:0];
    r.accepted = (chi < longint'(cfg_shadow.chi2_cut));
    return r;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
  endfunction

  // Queue helpers for pending words and expected scores.
  function automatic void add_pair(pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  function automatic void add_score(score_t s);
    expected_scores.insert(expected_scores.size(), s);
  endfunction

  function automatic pair_t pair_ch_word();
    pair_t p;
    p.up_x = pair_ch.up_x; p.up_y = pair_ch.up_y; p.up_z = pair_ch.up_z;
    p.up_tx = pair_ch.up_tx; p.up_ty = pair_ch.up_ty; p.up_bad = pair_ch.up_bad;
    p.down_x = pair_ch.down_x; p.down_y = pair_ch.down_y;
    p.down_z = pair_ch.down_z; p.down_tx = pair_ch.down_tx;
    p.down_ty = pair_ch.down_ty; p.down_ty_variance = pair_ch.down_ty_variance;
    return p;
  endfunction

  task automatic drive_pair(pair_t p);
    pair_ch.up_x <= p.up_x; pair_ch.up_y <= p.up_y; pair_ch.up_z <= p.up_z;
    pair_ch.up_tx <= p.up_tx; pair_ch.up_ty <= p.up_ty; pair_ch.up_bad <= p.up_bad;
    pair_ch.down_x <= p.down_x; pair_ch.down_y <= p.down_y;
    pair_ch.down_z <= p.down_z; pair_ch.down_tx <= p.down_tx;
    pair_ch.down_ty <= p.down_ty; pair_ch.down_ty_variance <= p.down_ty_variance;
  endtask

  task automatic check_score(score_t e);
    if (res_ch.chi_square !== e.chi_square) begin
      $error("chi_square: expected %0d, actual %0d", e.chi_square, res_ch.chi_square);
      failed = 1'b1;
    end
    if (res_ch.accepted !== e.accepted) begin
      $error("accepted: expected %0d, actual %0d", e.accepted, res_ch.accepted);
      failed = 1'b1;
    end
  endtask

  // Driver: presents queued words with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      pair_ch.valid <= 1'b0;
    end else if (pair_ch.valid && !pair_ch.ready) begin
      // Hold the word until it is taken.
    end else begin
      if (pair_ch.valid) add_score(score_pair(pair_ch_word()));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        pair_ch.valid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        drive_pair(pending_pairs.pop_front());
        pair_ch.valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        pair_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result word and stalls at random.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_scores.size() == 0) begin
          $error("result word with no expected score: chi_square %0d", res_ch.chi_square);
          failed = 1'b1;
        end else begin
          check_score(expected_scores.pop_front());
        end
        next_take_gap = pick_gap();
        take_gap <= (next_take_gap > 0) ? next_take_gap - 1 : 0;
        res_ch.ready <= (next_take_gap == 0);
      end else if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    if (cycle_count > MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Register write over the configuration port, mirrored in the shadow copy.
  task automatic write_reg(tsm_pkg::reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      tsm_pkg::REG_Z_MAGNET: cfg_shadow.z_magnet = value[17:0];
      tsm_pkg::REG_Z_MAGNET_TX_SQ: cfg_shadow.z_magnet_tx_sq = value[18:0];
      tsm_pkg::REG_Z_MAGNET_DS_SQ: cfg_shadow.z_magnet_dslope_sq = value[18:0];
      tsm_pkg::REG_Z_MATCH_PLANE: cfg_shadow.z_match_plane = value[17:0];
      tsm_pkg::REG_X_TOLERANCE: cfg_shadow.x_tolerance = value[13:0];
      tsm_pkg::REG_Y_TOLERANCE: cfg_shadow.y_tolerance = value[13:0];
      tsm_pkg::REG_BEND_COEFF: cfg_shadow.bend_coefficient = value[18:0];
      default: cfg_shadow.chi2_cut = value[23:0];
    endcase
  endtask

  // A plausible matching pair: downstream lies near the extrapolated upstream.
  function automatic pair_t near_pair();
    pair_t p;
    p = '0;
    p.up_x = 20'($urandom_range(0, 40000) - 20000);
    p.up_y = 20'($urandom_range(0, 40000) - 20000);
    p.up_z = 20'($urandom_range(0, 8000));
    p.up_tx = 16'($urandom_range(0, 8000) - 4000);
    p.up_ty = 16'($urandom_range(0, 6000) - 3000);
    p.down_tx = 16'(p.up_tx + $urandom_range(0, 400) - 200);
    p.down_ty = 16'(p.up_ty + $urandom_range(0, 20) - 10);
    p.down_z = 20'($urandom_range(140000, 150000));
    p.down_x = 20'(longint'(p.up_x)
               + ((longint'(p.down_z) - longint'(p.up_z)) * longint'(p.up_tx) >>> 14)
               + longint'($urandom_range(0, 600)) - 300);
    p.down_y = 20'(longint'(p.up_y)
               + ((longint'(p.down_z) - longint'(p.up_z)) * longint'(p.up_ty) >>> 14)
               + longint'($urandom_range(0, 400)) - 200);
    p.up_bad = ($urandom_range(0, 15) == 0);
    p.down_ty_variance = $urandom_range(1000, 400000);
    if ($urandom_range(0, 20) == 0) p.down_ty_variance = '0;
    return p;
  endfunction

  function automatic pair_t noise_pair();
    pair_t p;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    p = raw[$bits(pair_t)-1:0];
    if (p.down_ty_variance == 0) p.down_ty_variance = 32'd1;
    return p;
  endfunction

  task automatic wait_idle();
    while (pending_pairs.size() > 0 || pair_ch.valid || expected_scores.size() > 0)
      @(posedge clk);
  endtask

  task automatic run_phase(int count);
    for (int i = 0; i < count; i++)
      add_pair(($urandom_range(0, 3) == 0) ? noise_pair() : near_pair());
    wait_idle();
  endtask

  // Stimulus: directed extremes, then random phases under several settings.
  initial begin
    pair_t p;
    cfg_shadow = tsm_pkg::CFG_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words: zeros, field extremes, rejected and invalid tracks.
    p = '0; p.down_ty_variance = 32'd1; add_pair(p);
    p = '1; p.up_bad = 1'b0; add_pair(p);
    p.up_x = 20'sh7FFFF; p.up_y = 20'sh7FFFF; p.up_z = 20'sh7FFFF;
    p.up_tx = 16'sh7FFF; p.up_ty = 16'sh7FFF;
    p.down_x = 20'sh80000; p.down_y = 20'sh80000; p.down_z = 20'sh80000;
    p.down_tx = 16'sh8000; p.down_ty = 16'sh8000; p.down_ty_variance = 32'd1;
    add_pair(p);
    p.down_ty_variance = 32'hFFFF_FFFF; add_pair(p);
    p = near_pair(); p.up_bad = 1'b1; p.down_ty_variance = 32'd5000; add_pair(p);
    p = near_pair(); p.up_bad = 1'b0; p.down_ty_variance = '0; add_pair(p);
    p = near_pair(); p.up_bad = 1'b0; p.down_ty_variance = 32'hFFFF_FFFF;
    add_pair(p);
    for (int i = 0; i < 8; i++) begin
      p = near_pair(); p.up_bad = 1'b0; p.down_ty_variance = 32'd200000;
      add_pair(p);
    end
    wait_idle();

    // Zero tolerances: a pair with zero upstream slopes and equal x slopes makes both tolerances zero.
    write_reg(tsm_pkg::REG_X_TOLERANCE, 32'd0);
    write_reg(tsm_pkg::REG_Y_TOLERANCE, 32'd0);
    p = near_pair(); p.up_bad = 1'b0; p.down_tx = p.up_tx; p.down_ty_variance = 32'd7;
    p.up_tx = '0; p.up_ty = '0; p.down_tx = '0; add_pair(p);
    p.down_x = p.up_x; p.down_y = p.up_y; p.down_ty = '0; add_pair(p);
    run_phase(150);

    // Upper extremes of every register.
    write_reg(tsm_pkg::REG_Z_MAGNET, 32'h3FFFF);
    write_reg(tsm_pkg::REG_Z_MAGNET_TX_SQ, 32'h3FFFF);
    write_reg(tsm_pkg::REG_Z_MAGNET_DS_SQ, 32'h3FFFF);
    write_reg(tsm_pkg::REG_Z_MATCH_PLANE, 32'h3FFFF);
    write_reg(tsm_pkg::REG_X_TOLERANCE, 32'h3FFF);
    write_reg(tsm_pkg::REG_Y_TOLERANCE, 32'h3FFF);
    write_reg(tsm_pkg::REG_BEND_COEFF, 32'h3FFFF);
    write_reg(tsm_pkg::REG_CHI2_CUT, 32'hFFFFFF);
    run_phase(250);

    // Lower extremes.
    write_reg(tsm_pkg::REG_Z_MAGNET, 32'd0);
    write_reg(tsm_pkg::REG_Z_MAGNET_TX_SQ, 32'h40000);
    write_reg(tsm_pkg::REG_Z_MAGNET_DS_SQ, 32'h40000);
    write_reg(tsm_pkg::REG_Z_MATCH_PLANE, 32'd0);
    write_reg(tsm_pkg::REG_X_TOLERANCE, 32'd1);
    write_reg(tsm_pkg::REG_Y_TOLERANCE, 32'd1);
    write_reg(tsm_pkg::REG_BEND_COEFF, 32'h40000);
    write_reg(tsm_pkg::REG_CHI2_CUT, 32'd0);
    run_phase(250);

    // Nominal values with a loose cut, then random settings.
    cfg_shadow = tsm_pkg::CFG_RESET;
    write_reg(tsm_pkg::REG_Z_MAGNET, 32'(tsm_pkg::CFG_RESET.z_magnet));
    write_reg(tsm_pkg::REG_Z_MAGNET_TX_SQ, 32'(tsm_pkg::CFG_RESET.z_magnet_tx_sq));
    write_reg(tsm_pkg::REG_Z_MAGNET_DS_SQ, 32'(tsm_pkg::CFG_RESET.z_magnet_dslope_sq));
    write_reg(tsm_pkg::REG_Z_MATCH_PLANE, 32'(tsm_pkg::CFG_RESET.z_match_plane));
    write_reg(tsm_pkg::REG_X_TOLERANCE, 32'(tsm_pkg::CFG_RESET.x_tolerance));
    write_reg(tsm_pkg::REG_Y_TOLERANCE, 32'(tsm_pkg::CFG_RESET.y_tolerance));
    write_reg(tsm_pkg::REG_BEND_COEFF, 32'(tsm_pkg::CFG_RESET.bend_coefficient));
    write_reg(tsm_pkg::REG_CHI2_CUT, 32'd40000);
    run_phase(350);
    for (int k = 0; k < 8; k++) write_reg(tsm_pkg::reg_idx_t'(k), $urandom);
    run_phase(350);

    repeat (40) @(posedge clk);
    if (!failed && expected_scores.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
